// ===== sv/nfpa_pkg.sv =====
package nfpa_pkg;

  // Table geometry: one RAM row holds this many pages
  localparam int LANES  = 32;
  localparam int LANE_W = 5;

  // Field and register widths
  localparam int PAGE_W    = 12;
  localparam int SCAN_W    = 13;
  localparam int ROW_W     = SCAN_W - LANE_W;
  localparam int SCAN_MAX  = (1 << SCAN_W) - 1;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;

  // Default table size
  localparam int NUM_PAGES_DEF = 4096;

  // Register reset values
  localparam logic [SCAN_W-1:0] PAGE_COUNT_RST = 13'd4096;
  localparam logic [PAGE_W-1:0] USER_LOW_RST   = 12'd0;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_USER_LOW   = 1'd1;

  // Request codes
  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_MARK  = 2'd2;

  // Row scan control: which lanes of the row lie inside the search range
  typedef struct packed {
    logic              first;
    logic              last;
    logic [LANE_W-1:0] lo_lane;
    logic [LANE_W-1:0] hi_lane;
  } scan_ctl_t;

  // Row scan result: lowest free usable lane in range
  typedef struct packed {
    logic              hit;
    logic [LANE_W-1:0] lane;
  } scan_res_t;

endpackage

// ===== sv/nfpa_req_if.sv =====
interface nfpa_req_if import nfpa_pkg::*;;
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic [PAGE_W-1:0] page_index;
  logic              usable_bit;

  modport source (output valid, output req_type, output page_index, output usable_bit,
                  input ready);
  modport sink   (input valid, input req_type, input page_index, input usable_bit,
                  output ready);
endinterface

// ===== sv/nfpa_rsp_if.sv =====
interface nfpa_rsp_if import nfpa_pkg::*;;
  logic              valid;
  logic              ready;
  logic              found;
  logic [PAGE_W-1:0] result_page;

  modport source (output valid, output found, output result_page, input ready);
  modport sink   (input valid, input found, input result_page, output ready);
endinterface

// ===== sv/nfpa_ram.sv =====
module nfpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/nfpa_row_scan.sv =====
module nfpa_row_scan import nfpa_pkg::*; (
  input  logic [LANES-1:0] usable,
  input  logic [LANES-1:0] alloc,
  input  scan_ctl_t        ctl,
  output scan_res_t        res
);

  logic [LANES-1:0] lo_mask;
  logic [LANES-1:0] hi_mask;
  logic [LANES-1:0] cand;
  logic [LANE_W-1:0] lane;

  // Trim the row to the search range at its ends
  assign lo_mask = ctl.first ? ({LANES{1'b1}} << ctl.lo_lane) : {LANES{1'b1}};
  assign hi_mask = ctl.last ? ({LANES{1'b1}} >> (LANE_W'(LANES - 1) - ctl.hi_lane))
                            : {LANES{1'b1}};
  assign cand    = usable & ~alloc & lo_mask & hi_mask;

  // Lowest candidate lane wins
  always_comb begin
    lane = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (cand[i]) begin
        lane = LANE_W'(i);
      end
    end
  end

  assign res.hit  = |cand;
  assign res.lane = lane;

endmodule

// ===== sv/next_fit_page_allocator.sv =====
// Next-fit page allocator. Each page has a usable bit and an allocated bit, kept
// 32 pages to a row in one RAM. An allocate scans from the memo page up to
// min(page_count, NUM_PAGES), then wraps from user_low_page up to the memo,
// grants the first usable free page and moves the memo past it. Free and mark
// of a page in range read its row on accept, write it back in S_MODIFY and
// respond from S_RESP. An allocate reads one 32-page row per cycle through the
// single RAM read port until it finds a page or its wrapped pass ends. After
// reset the block clears the table, one row per cycle, before it takes the
// first item; register writes are taken throughout. Writing user_low_page also
// loads the memo.
module next_fit_page_allocator import nfpa_pkg::*; #(
  parameter int NUM_PAGES = NUM_PAGES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  nfpa_req_if.sink             req,
  nfpa_rsp_if.source           rsp
);

  localparam int NWORDS = (NUM_PAGES + LANES - 1) / LANES;
  localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam logic [SCAN_W-1:0] PAGE_CAP =
    SCAN_W'((NUM_PAGES > SCAN_MAX) ? SCAN_MAX : NUM_PAGES);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_SCAN, S_MODIFY, S_RESP} state_t;

  state_t              state;
  logic [AW-1:0]       clr_row;
  logic [SCAN_W-1:0]   page_count;
  logic [PAGE_W-1:0]   user_low;
  logic [SCAN_W-1:0]   memo;
  logic                pass;
  logic [SCAN_W-1:0]   lo;
  logic [SCAN_W-1:0]   hi;
  logic [ROW_W:0]      iss_row;
  logic [ROW_W-1:0]    chk_row;
  logic                chk_vld;
  logic [1:0]          op;
  logic                op_usable;
  logic [AW-1:0]       mod_row;
  logic [LANE_W-1:0]   mod_lane;
  logic                rsp_found;
  logic [PAGE_W-1:0]   rsp_page;
  logic                out_valid;
  logic                out_found;
  logic [PAGE_W-1:0]   out_page;

  logic                acc;
  logic                idx_in_range;
  logic [SCAN_W-1:0]   limit;
  logic [SCAN_W-1:0]   wrap_end;
  logic [SCAN_W-1:0]   hi_m1;
  logic [ROW_W-1:0]    lo_row;
  logic [ROW_W-1:0]    hi_row;
  logic                empty;
  logic                issue_ok;
  logic                hit;
  logic [SCAN_W-1:0]   found_page;
  scan_ctl_t           ctl;
  scan_res_t           res;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [2*LANES-1:0]  ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [2*LANES-1:0]  ram_q;
  logic [LANES-1:0]    q_usable;
  logic [LANES-1:0]    q_alloc;
  logic [LANES-1:0]    oh;
  logic [LANES-1:0]    new_usable;
  logic [LANES-1:0]    new_alloc;

  // Handshake
  assign req.ready    = (state == S_IDLE);
  assign acc          = req.valid && req.ready;
  assign idx_in_range = 32'(req.page_index) < NUM_PAGES;

  assign rsp.valid       = out_valid;
  assign rsp.found       = out_found;
  assign rsp.result_page = out_page;

  // Scan range of the current pass
  assign limit    = (page_count < PAGE_CAP) ? page_count : PAGE_CAP;
  assign wrap_end = (memo < PAGE_CAP) ? memo : PAGE_CAP;
  assign hi_m1    = hi - SCAN_W'(1);
  assign lo_row   = lo[SCAN_W-1:LANE_W];
  assign hi_row   = hi_m1[SCAN_W-1:LANE_W];
  assign empty    = (lo >= hi);
  assign issue_ok = (state == S_SCAN) && !empty && (iss_row <= {1'b0, hi_row});

  // Row under test
  assign q_usable    = ram_q[LANES-1:0];
  assign q_alloc     = ram_q[2*LANES-1:LANES];
  assign ctl.first   = (chk_row == lo_row);
  assign ctl.last    = (chk_row == hi_row);
  assign ctl.lo_lane = lo[LANE_W-1:0];
  assign ctl.hi_lane = hi_m1[LANE_W-1:0];

  nfpa_row_scan u_scan (
    .usable (q_usable),
    .alloc  (q_alloc),
    .ctl    (ctl),
    .res    (res)
  );

  assign hit        = (state == S_SCAN) && chk_vld && res.hit;
  assign found_page = {chk_row, res.lane};

  // Row update for grant, free and mark
  assign oh = LANES'(1) << mod_lane;

  always_comb begin
    new_usable = q_usable;
    new_alloc  = q_alloc;
    unique case (op)
      REQ_ALLOC: new_alloc = q_alloc | oh;
      REQ_FREE:  new_alloc = q_alloc & ~oh;
      REQ_MARK: begin
        new_usable = op_usable ? (q_usable | oh) : (q_usable & ~oh);
        new_alloc  = q_alloc & ~oh;
      end
      default: ;
    endcase
  end

  // RAM ports
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = mod_row;
    ram_wdata = {new_alloc, new_usable};
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_row;
      ram_wdata = '0;
    end else if (state == S_MODIFY) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = AW'(iss_row[ROW_W-1:0]);
    if (acc && (req.req_type == REQ_FREE || req.req_type == REQ_MARK) && idx_in_range) begin
      ram_re    = 1'b1;
      ram_raddr = AW'(req.page_index[PAGE_W-1:LANE_W]);
    end else if (issue_ok && !hit) begin
      ram_re = 1'b1;
    end
  end

  nfpa_ram #(
    .WIDTH (2 * LANES),
    .DEPTH (NWORDS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_q)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_row    <= '0;
      page_count <= PAGE_COUNT_RST;
      user_low   <= USER_LOW_RST;
      memo       <= SCAN_W'(USER_LOW_RST);
      chk_vld    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // the response state reloads the output register itself
      if (out_valid && rsp.ready && (state != S_RESP)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          clr_row <= clr_row + AW'(1);
          if (clr_row == AW'(NWORDS - 1)) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (acc) begin
            op        <= req.req_type;
            op_usable <= req.usable_bit;
            mod_row   <= AW'(req.page_index[PAGE_W-1:LANE_W]);
            mod_lane  <= req.page_index[LANE_W-1:0];
            case (req.req_type) inside
              REQ_ALLOC: begin
                pass    <= 1'b0;
                lo      <= memo;
                hi      <= limit;
                iss_row <= {1'b0, memo[SCAN_W-1:LANE_W]};
                chk_vld <= 1'b0;
                state   <= S_SCAN;
              end
              REQ_FREE, REQ_MARK: begin
                rsp_found <= 1'b1;
                rsp_page  <= '0;
                state     <= idx_in_range ? S_MODIFY : S_RESP;
              end
              default: begin
                rsp_found <= 1'b0;
                rsp_page  <= '0;
                state     <= S_RESP;
              end
            endcase
          end
        end

        S_SCAN: begin
          if (hit) begin
            mod_row   <= AW'(chk_row);
            mod_lane  <= res.lane;
            rsp_found <= 1'b1;
            rsp_page  <= found_page[PAGE_W-1:0];
            memo      <= found_page + SCAN_W'(1);
            chk_vld   <= 1'b0;
            state     <= S_MODIFY;
          end else if (issue_ok) begin
            chk_row <= iss_row[ROW_W-1:0];
            chk_vld <= 1'b1;
            iss_row <= iss_row + (ROW_W + 1)'(1);
          end else begin
            chk_vld <= 1'b0;
            if (!pass) begin
              // wrap to the user low page
              pass    <= 1'b1;
              lo      <= SCAN_W'(user_low);
              hi      <= wrap_end;
              iss_row <= (ROW_W + 1)'(user_low[PAGE_W-1:LANE_W]);
            end else begin
              rsp_found <= 1'b0;
              rsp_page  <= '0;
              state     <= S_RESP;
            end
          end
        end

        S_MODIFY: begin
          state <= S_RESP;
        end

        S_RESP: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_found <= rsp_found;
            out_page  <= rsp_page;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase

      // Register writes
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PAGE_COUNT: page_count <= cfg_data[SCAN_W-1:0];
          CFG_USER_LOW: begin
            user_low <= cfg_data[PAGE_W-1:0];
            memo     <= SCAN_W'(cfg_data[PAGE_W-1:0]);
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== test/next_fit_page_allocator_tb.sv =====
module next_fit_page_allocator_tb import nfpa_pkg::*;;

  localparam int          CYCLE_LIMIT = 400000;
  localparam int          HOLD_AT     = 150;
  localparam int          HOLD_CYCLES = 400;
  localparam int          DIR_ROWS    = 23;
  localparam int          PHASES      = 7;
  localparam logic [1:0]  REQ_UNUSED  = 2'd3;

  typedef struct packed {
    logic              found;
    logic [PAGE_W-1:0] page;
  } page_rsp_t;

  // One directed row: request fields, then an optional hand-written answer
  typedef struct packed {
    logic [1:0]        kind;
    logic [PAGE_W-1:0] page;
    logic              usable;
    logic              typed;
    logic              found;
    logic [PAGE_W-1:0] rpage;
  } dir_row_t;

  logic clk;
  logic rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  nfpa_req_if req_ch ();
  nfpa_rsp_if rsp_ch ();

  next_fit_page_allocator i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // Shadow of the page table and registers
  bit                model_alloc  [NUM_PAGES_DEF];
  bit                model_usable [NUM_PAGES_DEF];
  logic [SCAN_W-1:0] model_memo;
  logic [SCAN_W-1:0] model_page_count;
  logic [PAGE_W-1:0] model_user_low;

  page_rsp_t         pending_rsps [$];
  logic [PAGE_W-1:0] granted_pages [$];

  bit idle_on;
  int err_count;
  int items_sent;
  int results_seen;
  int alloc_hits;
  int alloc_misses;
  int cycles;

  // Directed items: extremes, every request kind, wrap and memo-past-limit scans
  dir_row_t dir_table [DIR_ROWS] = '{
    '{REQ_ALLOC,  12'd0,    1'b0, 1'b1, 1'b0, 12'd0},
    '{REQ_MARK,   12'd4095, 1'b1, 1'b1, 1'b1, 12'd0},
    '{REQ_ALLOC,  12'd0,    1'b0, 1'b1, 1'b1, 12'd4095},
    '{REQ_MARK,   12'd0,    1'b1, 1'b1, 1'b1, 12'd0},
    '{REQ_ALLOC,  12'd0,    1'b0, 1'b1, 1'b1, 12'd0},
    '{REQ_ALLOC,  12'd0,    1'b0, 1'b1, 1'b0, 12'd0},
    '{REQ_FREE,   12'd4095, 1'b0, 1'b1, 1'b1, 12'd0},
    '{REQ_ALLOC,  12'd4095, 1'b1, 1'b1, 1'b1, 12'd4095},
    '{REQ_UNUSED, 12'd4095, 1'b1, 1'b1, 1'b0, 12'd0},
    '{REQ_MARK,   12'd4095, 1'b0, 1'b1, 1'b1, 12'd0},
    '{REQ_ALLOC,  12'd0,    1'b0, 1'b1, 1'b0, 12'd0},
    '{REQ_FREE,   12'd0,    1'b0, 1'b1, 1'b1, 12'd0},
    '{REQ_MARK,   12'd2048, 1'b1, 1'b0, 1'b0, 12'd0},
    '{REQ_MARK,   12'd2049, 1'b1, 1'b0, 1'b0, 12'd0},
    '{REQ_ALLOC,  12'd0,    1'b0, 1'b0, 1'b0, 12'd0},
    '{REQ_ALLOC,  12'd0,    1'b0, 1'b0, 1'b0, 12'd0},
    '{REQ_ALLOC,  12'd0,    1'b0, 1'b0, 1'b0, 12'd0},
    '{REQ_ALLOC,  12'd0,    1'b0, 1'b0, 1'b0, 12'd0},
    '{REQ_FREE,   12'd2048, 1'b0, 1'b0, 1'b0, 12'd0},
    '{REQ_ALLOC,  12'd0,    1'b0, 1'b0, 1'b0, 12'd0},
    '{REQ_MARK,   12'd2730, 1'b1, 1'b0, 1'b0, 12'd0},
    '{REQ_MARK,   12'd1365, 1'b0, 1'b0, 1'b0, 12'd0},
    '{REQ_ALLOC,  12'd0,    1'b0, 1'b0, 1'b0, 12'd0}
  };

  // Register settings per random phase: page count, low user page, focus, items
  int unsigned phase_count [PHASES] = '{8191, 100, 0, 4096, 0, 64,   2048};
  int unsigned phase_low   [PHASES] = '{4095, 40,  0, 0,    0, 1000, 2000};
  int unsigned phase_focus [PHASES] = '{4048, 30,  0, 0,    0, 1000, 1990};
  int unsigned phase_items [PHASES] = '{80,   80,  30, 90,  80, 30,   80};

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_rsps.size());
      $display("next_fit_page_allocator_tb NOT OK");
      $finish;
    end
  end

  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // Take a page if usable and free; moves the memo past it
  function automatic bit claim_page(input int p);
    if (model_usable[p] && !model_alloc[p]) begin
      model_alloc[p] = 1'b1;
      model_memo     = SCAN_W'(p + 1);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Next-fit allocator behavior, applied to the shadow table
  function automatic page_rsp_t predict_response(input logic [1:0] kind,
                                                 input logic [PAGE_W-1:0] pg,
                                                 input logic u);
    page_rsp_t r;
    int limit;
    int wrap_end;
    int p;
    r = '0;
    case (kind)
      REQ_ALLOC: begin
        limit    = (int'(model_page_count) < NUM_PAGES_DEF) ? int'(model_page_count)
                                                            : NUM_PAGES_DEF;
        wrap_end = (int'(model_memo) < NUM_PAGES_DEF) ? int'(model_memo) : NUM_PAGES_DEF;
        for (p = int'(model_memo); p < limit && !r.found; p++) begin
          if (claim_page(p)) begin
            r.found = 1'b1;
            r.page  = PAGE_W'(p);
          end
        end
        for (p = int'(model_user_low); p < wrap_end && !r.found; p++) begin
          if (claim_page(p)) begin
            r.found = 1'b1;
            r.page  = PAGE_W'(p);
          end
        end
        if (r.found) begin
          alloc_hits++;
          granted_pages.push_back(r.page);
        end else begin
          alloc_misses++;
        end
      end
      REQ_FREE: begin
        model_alloc[pg] = 1'b0;
        r.found = 1'b1;
      end
      REQ_MARK: begin
        model_usable[pg] = u;
        model_alloc[pg]  = 1'b0;
        r.found = 1'b1;
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  // Offer one item, after a random gap while idle_on is set; predict once it is accepted
  task automatic send_item(input logic [1:0] kind, input logic [PAGE_W-1:0] pg,
                           input logic u, input bit typed, input page_rsp_t typed_rsp);
    int gap;
    page_rsp_t pred;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid      = 1'b1;
    req_ch.req_type   = kind;
    req_ch.page_index = pg;
    req_ch.usable_bit = u;
    do @(posedge clk); while (!req_ch.ready);
    pred = predict_response(kind, pg, u);
    pending_rsps.push_back(typed ? typed_rsp : pred);
    items_sent++;
    @(negedge clk);
  endtask

  // Random item: mostly pages near the focus window, frees often hit granted pages
  task automatic send_random(input int unsigned focus);
    logic [1:0]        kind;
    logic [PAGE_W-1:0] pg;
    logic              u;
    int unsigned       roll;
    int                k;
    roll = $urandom_range(0, 99);
    pg   = ($urandom_range(0, 4) != 0) ? PAGE_W'(focus + $urandom_range(0, 47))
                                       : PAGE_W'($urandom_range(0, 4095));
    u    = ($urandom_range(0, 3) != 0);
    if (roll < 30)      kind = REQ_MARK;
    else if (roll < 70) kind = REQ_ALLOC;
    else if (roll < 95) kind = REQ_FREE;
    else                kind = REQ_UNUSED;
    if (kind == REQ_FREE && granted_pages.size() > 0 && $urandom_range(0, 9) < 6) begin
      k  = $urandom_range(0, granted_pages.size() - 1);
      pg = granted_pages[k];
      granted_pages.delete(k);
    end
    send_item(kind, pg, u, 1'b0, '0);
  endtask

  // Wait for the block to go idle
  task automatic drain();
    req_ch.valid = 1'b0;
    while (pending_rsps.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we    = 1'b0;
    if (idx == CFG_PAGE_COUNT) begin
      model_page_count = data;
    end else begin
      model_user_low = data[PAGE_W-1:0];
      model_memo     = {1'b0, data[PAGE_W-1:0]};
    end
  endtask

  // Response side: random stalls, one long hold-off, field checks
  initial begin : response_side
    int        stall;
    bit        held;
    page_rsp_t exp_rsp;
    held = 1'b0;
    rsp_ch.ready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if (!held && results_seen >= HOLD_AT) begin
        held = 1'b1;
        rsp_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      stall = idle_on ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        rsp_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready = 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      results_seen++;
      if (pending_rsps.size() == 0) begin
        flag_error($sformatf("unexpected result found=%0b page=%0d",
                             rsp_ch.found, rsp_ch.result_page));
      end else begin
        exp_rsp = pending_rsps.pop_front();
        if (rsp_ch.found !== exp_rsp.found)
          flag_error($sformatf("result %0d found: expected %0b got %0b",
                               results_seen, exp_rsp.found, rsp_ch.found));
        if (rsp_ch.result_page !== exp_rsp.page)
          flag_error($sformatf("result %0d result_page: expected %0d got %0d",
                               results_seen, exp_rsp.page, rsp_ch.result_page));
      end
      @(negedge clk);
    end
  end

  // Main sequence
  initial begin : request_side
    int i;
    int n;
    page_rsp_t typed_rsp;
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = CFG_PAGE_COUNT;
    cfg_data          = '0;
    req_ch.valid      = 1'b0;
    req_ch.req_type   = REQ_ALLOC;
    req_ch.page_index = '0;
    req_ch.usable_bit = 1'b0;
    idle_on           = 1'b1;
    items_sent        = 0;
    alloc_hits        = 0;
    alloc_misses      = 0;
    for (i = 0; i < NUM_PAGES_DEF; i++) begin
      model_alloc[i]  = 1'b0;
      model_usable[i] = 1'b0;
    end
    model_page_count = PAGE_COUNT_RST;
    model_user_low   = USER_LOW_RST;
    model_memo       = {1'b0, USER_LOW_RST};

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table
    for (i = 0; i < DIR_ROWS; i++) begin
      typed_rsp.found = dir_table[i].found;
      typed_rsp.page  = dir_table[i].rpage;
      send_item(dir_table[i].kind, dir_table[i].page, dir_table[i].usable,
                dir_table[i].typed, typed_rsp);
    end

    // Random phases under different register settings
    phase_count[4] = $urandom_range(1, 4096);
    phase_low[4]   = $urandom_range(0, phase_count[4] - 1);
    phase_focus[4] = phase_low[4];
    phase_focus[3] = $urandom_range(0, 4047);
    for (i = 0; i < PHASES; i++) begin
      drain();
      write_reg(CFG_PAGE_COUNT, CFG_W'(phase_count[i]));
      write_reg(CFG_USER_LOW, CFG_W'(phase_low[i]));
      idle_on = (i % 2 == 0);
      for (n = 0; n < phase_items[i]; n++) send_random(phase_focus[i]);
    end

    // Wind down
    req_ch.valid = 1'b0;
    while (pending_rsps.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("%0d requests, %0d results, %0d grants, %0d empty scans, %0d register phases",
             items_sent, results_seen, alloc_hits, alloc_misses, PHASES + 1);
    $display("errors: %0d, cycles: %0d", err_count, cycles);
    if (err_count == 0 && pending_rsps.size() == 0) begin
      $display("next_fit_page_allocator_tb OK");
    end else begin
      $display("next_fit_page_allocator_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/nfpa_pkg.sv
sv/nfpa_req_if.sv
sv/nfpa_rsp_if.sv
sv/nfpa_ram.sv
sv/nfpa_row_scan.sv
sv/next_fit_page_allocator.sv
test/next_fit_page_allocator_tb.sv
